FILE: rtl/wes_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wes_pkg
// Shared types and constants for the weighted energy score block.
// ----------------------------------------------------------------------------
package wes_pkg;

	localparam int MaxMembers = 64;
	localparam int MaxDims    = 16;
	localparam int MiW        = $clog2(MaxMembers);
	localparam int DiW        = $clog2(MaxDims);
	localparam int MAddrW     = MiW + DiW;
	localparam int McW        = 7;
	localparam int DcW        = 5;
	localparam int AccW       = 38;   // 16 dims of 34-bit squares
	localparam int RootW      = AccW / 2;
	localparam int CrossW     = 40;
	localparam int PairW      = 45;
	localparam int ScoreW     = 46;
	localparam int CrossSumW  = CrossW + 1;
	localparam int PairSumW   = PairW + 1;

	localparam logic [1:0] REQ_OBS     = 2'd0;
	localparam logic [1:0] REQ_MEMBER  = 2'd1;
	localparam logic [1:0] REQ_COMPUTE = 2'd2;

	localparam logic [1:0] REG_MEMBER_COUNT = 2'd0;
	localparam logic [1:0] REG_DIM_COUNT    = 2'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_ACCUM,
		ST_ROOT,
		ST_WEIGH,
		ST_ADD,
		ST_OUT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic              clear_sums;
		logic              rd_en;
		logic [MiW-1:0]    rd_i;
		logic [MiW-1:0]    rd_j;
		logic [DiW-1:0]    rd_d;
		logic              pair_mode;
		logic              acc_clear;
		logic              acc_add;
		logic              root_start;
		logic              weigh;
		logic              add_term;
		logic              out_load;
	} wes_cmd_t;

	typedef struct packed {
		logic root_done;
	} wes_stat_t;

endpackage : wes_pkg
`default_nettype wire

FILE: rtl/wes_stream_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wes_stream_if
// Valid/ready channels for request and result items.
// ----------------------------------------------------------------------------
interface wes_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [5:0]  member_index;
	logic [3:0]  dim_index;
	logic signed [15:0] value;
	logic [15:0] weight;
	modport source (output valid, req_type, member_index, dim_index, value, weight,
		input ready);
	modport sink (input valid, req_type, member_index, dim_index, value, weight,
		output ready);
endinterface : wes_req_if

interface wes_res_if;
	logic        valid;
	logic        ready;
	logic [39:0] cross_part;
	logic [44:0] pair_part;
	logic signed [45:0] score;
	modport source (output valid, cross_part, pair_part, score, input ready);
	modport sink (input valid, cross_part, pair_part, score, output ready);
endinterface : wes_res_if
`default_nettype wire

FILE: rtl/weighted_energy_score.sv
`default_nettype none
// ----------------------------------------------------------------------------
// weighted_energy_score
// Weighted ensemble energy score with APB configuration.
//
//  channel | dir | transfer carries
//  req     | in  | req_type, member_index, dim_index, value, weight
//  res     | out | cross_part, pair_part, score
//  apb     | in  | member_count (0x0), dimension_count (0x4)
//
// Load items are written into the stores as they are accepted. A compute item
// walks N cross terms and N(N-1)/2 pair terms; each term runs through the store
// reads, the square-root unit and then weighting and accumulation.
// No item is accepted while a compute runs or its result awaits transfer.
// Reset sets member_count to 8 and dimension_count to 1.
// ----------------------------------------------------------------------------
module weighted_energy_score (
	input  wire logic        clk,
	input  wire logic        arst_n,
	wes_req_if.sink          req,
	wes_res_if.source        res,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import wes_pkg::*;

	logic [McW-1:0] member_count_q;
	logic [DcW-1:0] dimension_count_q;
	logic [1:0]     reg_idx;
	assign reg_idx = (paddr[1:0] == 2'b00) ? {1'b0, paddr[2]} : 2'd3;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			member_count_q    <= McW'(8);
			dimension_count_q <= DcW'(1);
		end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
			case (reg_idx)
				REG_MEMBER_COUNT: member_count_q    <= pwdata[McW-1:0];
				REG_DIM_COUNT:    dimension_count_q <= pwdata[DcW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (reg_idx)
			REG_MEMBER_COUNT: prdata = 32'(member_count_q);
			REG_DIM_COUNT:    prdata = 32'(dimension_count_q);
			default: ;
		endcase
	end

	logic      busy, out_set, valid_q, acc;
	wes_cmd_t  cmd;
	wes_stat_t stat;

	assign req.ready = !busy && !valid_q;
	assign acc       = req.valid && req.ready;

	wes_ctrl u_ctrl (
		.clk, .arst_n,
		.start(acc && req.req_type == REQ_COMPUTE),
		.member_count(member_count_q),
		.dimension_count(dimension_count_q),
		.stat, .out_free(!valid_q), .busy, .out_set, .cmd);

	wes_datapath u_dp (
		.clk, .arst_n,
		.ld_obs(acc && req.req_type == REQ_OBS),
		.ld_mem(acc && req.req_type == REQ_MEMBER),
		.ld_mi(req.member_index), .ld_di(req.dim_index),
		.ld_value(req.value), .ld_weight(req.weight),
		.cmd, .stat,
		.cross_q(res.cross_part), .pair_q(res.pair_part), .score_q(res.score));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_set) begin
			valid_q <= 1'b1;
		end else if (res.ready) begin
			valid_q <= 1'b0;
		end
	end
	assign res.valid = valid_q && !busy;
endmodule : weighted_energy_score
`default_nettype wire

FILE: rtl/wes_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wes_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wes_ram #(
	parameter int Width = 16,
	parameter int Depth = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule : wes_ram
`default_nettype wire

FILE: rtl/wes_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wes_datapath
// Stores, squared-difference accumulator, bit-serial square root, weighting
// and the two running sums.
// ----------------------------------------------------------------------------
module wes_datapath (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               ld_obs,
	input  wire logic               ld_mem,
	input  wire logic [5:0]         ld_mi,
	input  wire logic [3:0]         ld_di,
	input  wire logic [15:0]        ld_value,
	input  wire logic [15:0]        ld_weight,
	input  wire wes_pkg::wes_cmd_t  cmd,
	output wes_pkg::wes_stat_t      stat,
	output logic [39:0]             cross_q,
	output logic [44:0]             pair_q,
	output logic [45:0]             score_q
);
	import wes_pkg::*;

	logic [15:0] obs_rd, mi_rd, mj_rd, wi_rd, wj_rd;

	wes_ram #(.Width(16), .Depth(MaxDims)) u_obs (
		.clk, .we(ld_obs), .waddr(ld_di), .wdata(ld_value),
		.re(cmd.rd_en), .raddr(cmd.rd_d), .rdata(obs_rd));
	wes_ram #(.Width(16), .Depth(MaxMembers*MaxDims)) u_mem_i (
		.clk, .we(ld_mem), .waddr({ld_mi, ld_di}), .wdata(ld_value),
		.re(cmd.rd_en), .raddr({cmd.rd_i, cmd.rd_d}), .rdata(mi_rd));
	wes_ram #(.Width(16), .Depth(MaxMembers*MaxDims)) u_mem_j (
		.clk, .we(ld_mem), .waddr({ld_mi, ld_di}), .wdata(ld_value),
		.re(cmd.rd_en), .raddr({cmd.rd_j, cmd.rd_d}), .rdata(mj_rd));
	wes_ram #(.Width(16), .Depth(MaxMembers)) u_w_i (
		.clk, .we(ld_mem), .waddr(ld_mi), .wdata(ld_weight),
		.re(cmd.rd_en), .raddr(cmd.rd_i), .rdata(wi_rd));
	wes_ram #(.Width(16), .Depth(MaxMembers)) u_w_j (
		.clk, .we(ld_mem), .waddr(ld_mi), .wdata(ld_weight),
		.re(cmd.rd_en), .raddr(cmd.rd_j), .rdata(wj_rd));

	// Squared difference of the read pair.
	logic signed [16:0] diff;
	logic [16:0]        mag;
	logic [33:0]        sq;
	logic [AccW-1:0]    acc_q;
	logic [15:0]        wi_q, wj_q;
	assign diff = $signed({mi_rd[15], mi_rd})
		- (cmd.pair_mode ? $signed({mj_rd[15], mj_rd}) : $signed({obs_rd[15], obs_rd}));
	assign mag  = diff[16] ? 17'(-diff) : 17'(diff);
	assign sq   = mag * mag;

	always_ff @(posedge clk) begin
		if (cmd.acc_clear) begin
			acc_q <= '0;
		end else if (cmd.acc_add) begin
			acc_q <= acc_q + AccW'(sq);
		end
	end

	// The weight reads still hold the pair fetched for this term.
	always_ff @(posedge clk) begin
		if (cmd.root_start) begin
			wi_q <= wi_rd;
			wj_q <= wj_rd;
		end
	end

	// Restoring square root, one result bit per cycle.
	logic [RootW-1:0] root_q;
	logic [4:0]       rcnt_q;
	logic [RootW+1:0] trial;
	// The partial remainder takes in two radicand bits per step.
	logic [AccW-1:0]  rad_q;
	logic [RootW+1:0] pr_next;
	logic [RootW+1:0] pr_q;
	assign pr_next = {pr_q[RootW-1:0], rad_q[AccW-1:AccW-2]};
	assign trial   = {root_q, 2'b01};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rcnt_q <= '0;
		end else if (cmd.root_start) begin
			rcnt_q <= 5'(RootW);
		end else if (rcnt_q != 5'd0) begin
			rcnt_q <= rcnt_q - 5'd1;
		end
	end
	always_ff @(posedge clk) begin
		if (cmd.root_start) begin
			rad_q  <= acc_q;
			pr_q   <= '0;
			root_q <= '0;
		end else if (rcnt_q != 5'd0) begin
			rad_q <= {rad_q[AccW-3:0], 2'b00};
			if (pr_next >= trial) begin
				pr_q   <= pr_next - trial;
				root_q <= {root_q[RootW-2:0], 1'b1};
			end else begin
				pr_q   <= pr_next;
				root_q <= {root_q[RootW-2:0], 1'b0};
			end
		end
	end
	assign stat.root_done = (rcnt_q == 5'd0) && !cmd.root_start;

	// Weighting: the truncated weight product (pair mode) or the weight of i (cross mode), then times the distance.
	logic [31:0]       wprod;
	logic [15:0]       wsel_q;
	logic [RootW-1:0]  dist_q;
	logic [RootW+15:0] term_s1;
	assign wprod = wi_q * wj_q;
	always_ff @(posedge clk) begin
		if (cmd.weigh) begin
			wsel_q <= cmd.pair_mode ? wprod[31:16] : wi_q;
			dist_q <= root_q;
		end
		term_s1 <= wsel_q * dist_q;
	end

	logic [CrossSumW-1:0] csum;
	logic [PairSumW-1:0]  psum;
	assign csum = {1'b0, cross_q} + CrossSumW'(term_s1);
	assign psum = {1'b0, pair_q} + PairSumW'(term_s1);
	always_ff @(posedge clk) begin
		if (cmd.clear_sums) begin
			cross_q <= '0;
			pair_q  <= '0;
		end else if (cmd.add_term) begin
			if (cmd.pair_mode) begin
				pair_q <= psum[PairW] ? '1 : psum[PairW-1:0];
			end else begin
				cross_q <= csum[CrossW] ? '1 : csum[CrossW-1:0];
			end
		end
		if (cmd.out_load) begin
			score_q <= ScoreW'(cross_q) - ScoreW'(pair_q);
		end
	end
endmodule : wes_datapath
`default_nettype wire

FILE: rtl/wes_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wes_ctrl
// Sequencer that walks members, member pairs and dimensions.
// ----------------------------------------------------------------------------
module wes_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [6:0]         member_count,
	input  wire logic [4:0]         dimension_count,
	input  wire wes_pkg::wes_stat_t stat,
	input  wire logic               out_free,
	output logic                    busy,
	output logic                    out_set,
	output wes_pkg::wes_cmd_t       cmd
);
	import wes_pkg::*;

	state_t state_q, state_d;
	logic [McW-1:0] m_q;
	logic [DcW-1:0] dims_q;
	logic [McW-1:0] i_q, j_q;
	logic [DcW-1:0] d_q;
	logic           pair_q;
	logic           wait_q;
	logic [McW-1:0] m_sat;
	logic [DcW-1:0] d_sat;
	logic           last_d, more_j, more_i;

	assign m_sat  = (member_count > McW'(MaxMembers)) ? McW'(MaxMembers) : member_count;
	assign d_sat  = (dimension_count > DcW'(MaxDims)) ? DcW'(MaxDims) : dimension_count;
	assign last_d = (d_q + DcW'(1)) >= dims_q;
	// After a term: in cross mode move to pairs of i; in pair mode next j.
	assign more_j = pair_q ? (j_q + McW'(1) < m_q) : (i_q + McW'(1) < m_q);
	assign more_i = (i_q + McW'(1)) < m_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (start) state_d = (m_sat == '0) ? ST_OUT : ST_FETCH;
			ST_FETCH: state_d = (dims_q == '0) ? ST_ROOT : ST_ACCUM;
			ST_ACCUM: if (last_d) state_d = ST_ROOT; else state_d = ST_ACCUM;
			ST_ROOT:  if (stat.root_done && wait_q) state_d = ST_WEIGH;
			ST_WEIGH: state_d = ST_ADD;
			ST_ADD: begin
				if (!wait_q) state_d = ST_ADD;
				else if (!pair_q && !more_i) state_d = ST_OUT;
				else if (pair_q && !more_j && !more_i) state_d = ST_OUT;
				else state_d = ST_FETCH;
			end
			ST_OUT:   if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			m_q     <= '0;
			dims_q  <= '0;
			i_q     <= '0;
			j_q     <= '0;
			d_q     <= '0;
			pair_q  <= 1'b0;
			wait_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					m_q    <= m_sat;
					dims_q <= d_sat;
					i_q    <= '0;
					j_q    <= '0;
					d_q    <= '0;
					pair_q <= 1'b0;
				end
				// d_q names the element whose read data arrives in this cycle.
				ST_FETCH: d_q <= '0;
				ST_ACCUM: d_q <= last_d ? '0 : d_q + DcW'(1);
				ST_ROOT:  wait_q <= 1'b1;
				ST_WEIGH: wait_q <= 1'b0;
				ST_ADD: begin
					wait_q <= !wait_q;
					if (wait_q) begin
						// Order: cross term of i, then pairs (i,j) for j>i, then i+1.
						if (!pair_q) begin
							if (more_i) begin
								pair_q <= 1'b1;
								j_q    <= i_q + McW'(1);
							end
						end else if (more_j) begin
							j_q <= j_q + McW'(1);
						end else begin
							pair_q <= 1'b0;
							i_q    <= i_q + McW'(1);
						end
					end
				end
				default: ;
			endcase
		end
	end

	logic [DcW-1:0] rd_d;
	assign rd_d = (state_q == ST_FETCH) ? '0 : d_q + DcW'(1);

	always_comb begin
		cmd = '0;
		cmd.rd_i      = i_q[MiW-1:0];
		cmd.rd_j      = j_q[MiW-1:0];
		cmd.rd_d      = rd_d[DiW-1:0];
		cmd.pair_mode = pair_q;
		busy    = (state_q != ST_IDLE);
		out_set = 1'b0;
		case (state_q)
			ST_IDLE:  cmd.clear_sums = start;
			ST_FETCH: begin
				cmd.rd_en     = 1'b1;
				cmd.acc_clear = 1'b1;
			end
			ST_ACCUM: begin
				cmd.rd_en   = 1'b1;
				cmd.acc_add = 1'b1;
			end
			ST_ROOT:  cmd.root_start = !wait_q;
			ST_WEIGH: cmd.weigh = 1'b1;
			ST_ADD:   cmd.add_term = wait_q;
			ST_OUT: begin
				cmd.out_load = out_free;
				out_set      = out_free;
			end
			default: ;
		endcase
	end
endmodule : wes_ctrl
`default_nettype wire
